// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

	// operation codes on the request channel
	typedef enum logic [1:0] {
		FUNC_ENQUEUE = 2'd0,
		FUNC_DEQUEUE = 2'd1,
		FUNC_REMOVE  = 2'd2,
		FUNC_NOP     = 2'd3
	} spq_func_t;

	// status codes on the response channel
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} spq_status_t;

	typedef enum logic {
		S_IDLE,
		S_REMOVE
	} spq_state_t;

	// what every cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_COMPACT
	} spq_cell_op_t;

	typedef struct packed {
		spq_cell_op_t op;
		logic         occupied;
	} spq_cell_cmd_t;

	// handed from each cell to its right-hand neighbour
	typedef struct packed {
		logic lt;   // holds an entry of lower priority than the key
		logic seen; // a matching entry sits here or further left
	} spq_link_t;

endpackage

`default_nettype wire

// ===== rtl/spq_req_if.sv =====
`default_nettype none

interface spq_req_if #(
	parameter int VALUE_BITS    = 16,
	parameter int PRIORITY_BITS = 8
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               func;
	logic [VALUE_BITS-1:0]    in_value;
	logic [PRIORITY_BITS-1:0] in_priority;

	modport source (output valid, func, in_value, in_priority, input ready);
	modport sink   (input valid, func, in_value, in_priority, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_rsp_if.sv =====
`default_nettype none

interface spq_rsp_if #(
	parameter int VALUE_BITS    = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int COUNT_BITS    = 5
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [VALUE_BITS-1:0]    out_value;
	logic [PRIORITY_BITS-1:0] out_priority;
	logic [COUNT_BITS-1:0]    removed_count;
	logic [COUNT_BITS-1:0]    occupancy;
	logic                     now_empty;
	logic                     now_full;

	modport source (output valid, status, out_value, out_priority, removed_count,
		occupancy, now_empty, now_full, input ready);
	modport sink   (input valid, status, out_value, out_priority, removed_count,
		occupancy, now_empty, now_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

// One slot of the sorted list. Inserts shift right, compaction shifts left.
module spq_cell #(
	parameter int VALUE_BITS    = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  wire                             clk,
	input  spq_pkg::spq_cell_cmd_t          cmd,
	input  wire logic [PRIORITY_BITS-1:0]   key,
	input  wire logic [VALUE_BITS-1:0]      new_val,
	input  spq_pkg::spq_link_t              link_in,
	output spq_pkg::spq_link_t              link_out,
	input  wire logic [VALUE_BITS-1:0]      left_val,
	input  wire logic [PRIORITY_BITS-1:0]   left_prio,
	input  wire logic [VALUE_BITS-1:0]      right_val,
	input  wire logic [PRIORITY_BITS-1:0]   right_prio,
	output logic      [VALUE_BITS-1:0]      cell_val,
	output logic      [PRIORITY_BITS-1:0]   cell_prio
);

	logic [VALUE_BITS-1:0]    val_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic                     match;

	assign match         = cmd.occupied && (prio_q == key);
	assign link_out.lt   = cmd.occupied && (prio_q < key);
	assign link_out.seen = link_in.seen | match;
	assign cell_val      = val_q;
	assign cell_prio     = prio_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			spq_pkg::CELL_INSERT: begin
				if (!link_out.lt) begin
					if (link_in.lt) begin
						val_q  <= new_val;
						prio_q <= key;
					end else begin
						val_q  <= left_val;
						prio_q <= left_prio;
					end
				end
			end
			spq_pkg::CELL_COMPACT: begin
				if (link_out.seen) begin
					val_q  <= right_val;
					prio_q <= right_prio;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: holds up to CAPACITY value/priority pairs in a row of
// cells, slot 0 the lowest priority. Enqueue inserts ahead of the first entry
// of equal or greater priority; dequeue returns the tail (greatest priority,
// oldest among equals); remove-priority deletes every entry of one priority.
// Each request transfer yields exactly one response transfer. Enqueue, dequeue,
// the unused code and remove on an empty queue are done in the cycle of the
// request transfer, so the response is on the port in the next cycle and a new
// request can be taken every cycle while responses are taken. Remove-priority
// on a non-empty queue then compacts the chain, closing one gap per cycle, until
// none of the matching entries (at most CAPACITY of them) is left, and registers
// its response once the response register is free; no request is taken until
// that response is registered.
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY      = 16,
	parameter int VALUE_BITS    = 16,
	parameter int PRIORITY_BITS = 8
) (
	input wire      clk,
	input wire      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1); // entry count
	localparam int IW = $clog2(CAPACITY);     // slot index

	// ---------------------------------------------------------------
	// state
	// ---------------------------------------------------------------
	spq_pkg::spq_state_t      state_q, state_d;
	logic [CW-1:0]            count_q, count_d;
	logic [CW-1:0]            rc_q, rc_d;       // removed so far
	logic [PRIORITY_BITS-1:0] key_q, key_d;     // priority being removed

	// response register
	logic                     rsp_valid_q;
	spq_pkg::spq_status_t     status_q;
	logic [VALUE_BITS-1:0]    out_val_q;
	logic [PRIORITY_BITS-1:0] out_prio_q;
	logic [CW-1:0]            out_rc_q;
	logic [CW-1:0]            occ_q;

	// ---------------------------------------------------------------
	// cell chain
	// ---------------------------------------------------------------
	spq_pkg::spq_cell_op_t    cell_op;
	logic [PRIORITY_BITS-1:0] key;
	spq_pkg::spq_link_t       link [CAPACITY+1];
	logic [VALUE_BITS-1:0]    pad_val  [CAPACITY+2];
	logic [PRIORITY_BITS-1:0] pad_prio [CAPACITY+2];
	logic [VALUE_BITS-1:0]    cell_val  [CAPACITY];
	logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];

	// insertion point seen from the left of slot 0; nothing matched yet
	assign link[0] = '{lt: 1'b1, seen: 1'b0};
	// ends of the chain: contents only land in slots past the count
	assign pad_val[0]           = '0;
	assign pad_prio[0]          = '0;
	assign pad_val[CAPACITY+1]  = '0;
	assign pad_prio[CAPACITY+1] = '0;

	assign key = (state_q == spq_pkg::S_REMOVE) ? key_q : req.in_priority;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::spq_cell_cmd_t cmd;

		assign cmd.op       = cell_op;
		assign cmd.occupied = count_q > CW'(i);
		assign pad_val[i+1]  = cell_val[i];
		assign pad_prio[i+1] = cell_prio[i];

		spq_cell #(
			.VALUE_BITS   (VALUE_BITS),
			.PRIORITY_BITS(PRIORITY_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.key       (key),
			.new_val   (req.in_value),
			.link_in   (link[i]),
			.link_out  (link[i+1]),
			.left_val  (pad_val[i]),
			.left_prio (pad_prio[i]),
			.right_val (pad_val[i+2]),
			.right_prio(pad_prio[i+2]),
			.cell_val  (cell_val[i]),
			.cell_prio (cell_prio[i])
		);
	end

	// tail slot, read on dequeue (only when the count is non-zero)
	logic [IW-1:0] tail_idx;
	assign tail_idx = IW'(count_q - CW'(1));

	// ---------------------------------------------------------------
	// control
	// ---------------------------------------------------------------
	logic                     rsp_free;
	logic                     req_fire;
	logic                     load_rsp;
	spq_pkg::spq_status_t     res_status;
	logic [VALUE_BITS-1:0]    res_val;
	logic [PRIORITY_BITS-1:0] res_prio;
	logic [CW-1:0]            res_rc;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == spq_pkg::S_IDLE) && rsp_free;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		rc_q  <= rc_d;
		key_q <= key_d;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rc_d       = rc_q;
		key_d      = key_q;
		cell_op    = spq_pkg::CELL_HOLD;
		load_rsp   = 1'b0;
		res_status = spq_pkg::ST_OK;
		res_val    = '0;
		res_prio   = '0;
		res_rc     = '0;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (req_fire) begin
					unique case (spq_pkg::spq_func_t'(req.func))
						spq_pkg::FUNC_ENQUEUE: begin
							load_rsp = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								res_status = spq_pkg::ST_FULL;
							end else begin
								cell_op = spq_pkg::CELL_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						spq_pkg::FUNC_DEQUEUE: begin
							load_rsp = 1'b1;
							if (count_q == '0) begin
								res_status = spq_pkg::ST_EMPTY;
							end else begin
								res_val  = cell_val[tail_idx];
								res_prio = cell_prio[tail_idx];
								count_d  = count_q - CW'(1);
							end
						end
						spq_pkg::FUNC_REMOVE: begin
							if (count_q == '0) begin
								load_rsp   = 1'b1;
								res_status = spq_pkg::ST_EMPTY;
							end else begin
								state_d = spq_pkg::S_REMOVE;
								key_d   = req.in_priority;
								rc_d    = '0;
							end
						end
						default: begin
							load_rsp = 1'b1;
						end
					endcase
				end
			end
			spq_pkg::S_REMOVE: begin
				// a match anywhere shows at the right end of the chain
				if (link[CAPACITY].seen) begin
					cell_op = spq_pkg::CELL_COMPACT;
					count_d = count_q - CW'(1);
					rc_d    = rc_q + CW'(1);
				end else if (rsp_free) begin
					load_rsp   = 1'b1;
					res_rc     = rc_q;
					res_status = (rc_q == '0) ? spq_pkg::ST_NOTFOUND : spq_pkg::ST_OK;
					state_d    = spq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// response register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			status_q   <= res_status;
			out_val_q  <= res_val;
			out_prio_q <= res_prio;
			out_rc_q   <= res_rc;
			occ_q      <= count_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.out_value     = out_val_q;
	assign rsp.out_priority  = out_prio_q;
	assign rsp.removed_count = out_rc_q;
	assign rsp.occupancy     = occ_q;
	assign rsp.now_empty     = occ_q == '0;
	assign rsp.now_full      = occ_q == CW'(CAPACITY);

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q == spq_pkg::ST_FULL) |-> rsp.now_full)
		else $error("full rejection reported below capacity");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.func == spq_pkg::FUNC_ENQUEUE) && (count_q != CW'(CAPACITY))
		|=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not add one entry");

	for (genvar i = 1; i < CAPACITY; i++) begin : g_sorted
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(count_q > CW'(i)) |-> (cell_prio[i-1] <= cell_prio[i]))
			else $error("held entries out of priority order");
	end

endmodule

`default_nettype wire

// ===== bench/tb_sorted_priority_queue.sv =====
`default_nettype none

// Bench for the sorted priority queue. A shadow list of value/priority pairs,
// kept in step with every request transfer, predicts each response; the
// monitor compares every response transfer field by field with the oldest
// outstanding prediction. Stimulus: a short directed run (empty, full, no
// match, bulk removal, unused code, field extremes), then random bursts
// biased towards filling, draining or removing, under four handshake regimes.
module tb_sorted_priority_queue;

	localparam int CAPACITY      = 16;
	localparam int VALUE_BITS    = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int COUNT_BITS    = 5;
	localparam int CLK_HALF      = 4;
	localparam int RANDOM_ITEMS  = 385;	// per handshake phase
	localparam int DRAIN_CYCLES  = 40;	// covers the longest remove

	typedef struct packed {
		spq_pkg::spq_func_t       func;
		logic [VALUE_BITS-1:0]    value;
		logic [PRIORITY_BITS-1:0] prio;
	} request_t;

	typedef struct packed {
		spq_pkg::spq_status_t     status;
		logic [VALUE_BITS-1:0]    out_value;
		logic [PRIORITY_BITS-1:0] out_priority;
		logic [COUNT_BITS-1:0]    removed_count;
		logic [COUNT_BITS-1:0]    occupancy;
		logic                     now_empty;
		logic                     now_full;
	} response_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if #(.VALUE_BITS(VALUE_BITS), .PRIORITY_BITS(PRIORITY_BITS)) req_ch ();
	spq_rsp_if #(.VALUE_BITS(VALUE_BITS), .PRIORITY_BITS(PRIORITY_BITS),
		.COUNT_BITS(COUNT_BITS)) rsp_ch ();

	sorted_priority_queue #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS),
		.PRIORITY_BITS(PRIORITY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// requests waiting to be driven, and responses predicted but not yet seen
	request_t  pending_requests[$];
	response_t awaited_responses[$];

	// shadow of the queue contents: slot 0 is the head (lowest priority)
	logic [VALUE_BITS-1:0]    shadow_value[CAPACITY];
	logic [PRIORITY_BITS-1:0] shadow_prio[CAPACITY];
	int                       shadow_held;

	int sender_idle_pct;
	int receiver_stall_pct;
	int error_count;
	int responses_seen;
	int requests_sent;

	// coverage tallies for the closing summary
	int n_inserted, n_rejected, n_popped, n_empty_hits, n_notfound, n_purged;
	int n_nop, n_full_seen, n_whole_purge;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// known values on every input from time zero
	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.func        = '0;
		req_ch.in_value    = '0;
		req_ch.in_priority = '0;
		rsp_ch.ready       = 1'b0;
	end

	initial begin
		#(2 * CLK_HALF * 700000);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("response %0d %s: got %0d, want %0d", responses_seen, name,
				got, want));
	endtask

	// Apply one request to the shadow list and return the response it must give.
	function automatic response_t predict_response(input request_t r);
		response_t rs;
		int        pos;
		int        k;
		int        kept;
		rs = '0;
		case (r.func)
			spq_pkg::FUNC_ENQUEUE: begin
				if (shadow_held == CAPACITY) begin
					rs.status = spq_pkg::ST_FULL;
					n_rejected++;
				end else begin
					// newest goes ahead of every equal priority
					pos = 0;
					while (pos < shadow_held && shadow_prio[pos] < r.prio)
						pos++;
					for (k = shadow_held; k > pos; k--) begin
						shadow_value[k] = shadow_value[k-1];
						shadow_prio[k]  = shadow_prio[k-1];
					end
					shadow_value[pos] = r.value;
					shadow_prio[pos]  = r.prio;
					shadow_held++;
					n_inserted++;
				end
			end
			spq_pkg::FUNC_DEQUEUE: begin
				if (shadow_held == 0) begin
					rs.status = spq_pkg::ST_EMPTY;
					n_empty_hits++;
				end else begin
					shadow_held--;
					rs.out_value    = shadow_value[shadow_held];
					rs.out_priority = shadow_prio[shadow_held];
					n_popped++;
				end
			end
			spq_pkg::FUNC_REMOVE: begin
				if (shadow_held == 0) begin
					rs.status = spq_pkg::ST_EMPTY;
					n_empty_hits++;
				end else begin
					kept = 0;
					for (k = 0; k < shadow_held; k++) begin
						if (shadow_prio[k] != r.prio) begin
							shadow_value[kept] = shadow_value[k];
							shadow_prio[kept]  = shadow_prio[k];
							kept++;
						end
					end
					rs.removed_count = COUNT_BITS'(shadow_held - kept);
					if (kept == 0)
						n_whole_purge++;
					shadow_held = kept;
					if (rs.removed_count == 0) begin
						rs.status = spq_pkg::ST_NOTFOUND;
						n_notfound++;
					end else begin
						n_purged++;
					end
				end
			end
			default: begin
				n_nop++;
			end
		endcase
		rs.occupancy = COUNT_BITS'(shadow_held);
		rs.now_empty = (shadow_held == 0);
		rs.now_full  = (shadow_held == CAPACITY);
		if (rs.now_full)
			n_full_seen++;
		return rs;
	endfunction

	// Driver: holds an item until its transfer, then maybe idles before the next.
	always @(posedge clk or negedge arst_n) begin
		request_t nxt;
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.func        <= '0;
			req_ch.in_value    <= '0;
			req_ch.in_priority <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) begin
				// transfer at this edge: fields still hold the accepted item
				nxt.func  = spq_pkg::spq_func_t'(req_ch.func);
				nxt.value = req_ch.in_value;
				nxt.prio  = req_ch.in_priority;
				awaited_responses.push_back(predict_response(nxt));
				requests_sent++;
			end
			if (pending_requests.size() != 0 &&
				$urandom_range(99) >= sender_idle_pct) begin
				nxt = pending_requests.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.func        <= nxt.func;
				req_ch.in_value    <= nxt.value;
				req_ch.in_priority <= nxt.prio;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure, every response transfer checked in order.
	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_responses.size() == 0) begin
					report($sformatf("response %0d with no request outstanding",
						responses_seen));
				end else begin
					want = awaited_responses.pop_front();
					check_field("status", rsp_ch.status, want.status);
					check_field("out_value", rsp_ch.out_value, want.out_value);
					check_field("out_priority", rsp_ch.out_priority, want.out_priority);
					check_field("removed_count", rsp_ch.removed_count, want.removed_count);
					check_field("occupancy", rsp_ch.occupancy, want.occupancy);
					check_field("now_empty", rsp_ch.now_empty, want.now_empty);
					check_field("now_full", rsp_ch.now_full, want.now_full);
				end
				responses_seen++;
			end
			rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic request_t make_request(input spq_pkg::spq_func_t f, input int v,
		input int p);
		request_t r;
		r.func  = f;
		r.value = VALUE_BITS'(v);
		r.prio  = PRIORITY_BITS'(p);
		return r;
	endfunction

	// Random bursts: each favours filling, draining, removing, or a mix, and
	// draws priorities mostly from a narrow band so that equal ones collide.
	task automatic queue_random_bursts(input int count);
		int                 mode;
		int                 burst;
		int                 roll;
		int                 band;
		int                 p;
		spq_pkg::spq_func_t f;
		while (count > 0) begin
			mode  = $urandom_range(3);
			burst = $urandom_range(4, 40);
			if (burst > count)
				burst = count;
			roll  = $urandom_range(9);
			band  = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(255);
			repeat (burst) begin
				roll = $urandom_range(99);
				if (roll < 2)
					f = spq_pkg::FUNC_NOP;
				else case (mode)
					0: f = (roll < 85) ? spq_pkg::FUNC_ENQUEUE
						: (roll < 95) ? spq_pkg::FUNC_DEQUEUE : spq_pkg::FUNC_REMOVE;
					1: f = (roll < 80) ? spq_pkg::FUNC_DEQUEUE
						: (roll < 95) ? spq_pkg::FUNC_ENQUEUE : spq_pkg::FUNC_REMOVE;
					2: f = (roll < 45) ? spq_pkg::FUNC_REMOVE
						: (roll < 90) ? spq_pkg::FUNC_ENQUEUE : spq_pkg::FUNC_DEQUEUE;
					default: f = (roll < 40) ? spq_pkg::FUNC_ENQUEUE
						: (roll < 70) ? spq_pkg::FUNC_DEQUEUE : spq_pkg::FUNC_REMOVE;
				endcase
				p = ($urandom_range(99) < 70) ? (band ^ $urandom_range(3)) : $urandom_range(255);
				pending_requests.push_back(make_request(f, $urandom_range(65535), p));
			end
			count -= burst;
		end
	endtask

	task automatic wait_quiet();
		while (pending_requests.size() != 0 || req_ch.valid ||
			awaited_responses.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int k;
		int idle_table[4][2];
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		error_count        = 0;
		shadow_held        = 0;
		idle_table = '{'{0, 0}, '{78, 0}, '{0, 78}, '{33, 33}};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-queue cases, unused code carrying nonzero fields
		pending_requests.push_back(make_request(spq_pkg::FUNC_DEQUEUE, 16'hFFFF, 8'hFF));
		pending_requests.push_back(make_request(spq_pkg::FUNC_REMOVE, 0, 8'hFF));
		pending_requests.push_back(make_request(spq_pkg::FUNC_NOP, 16'hFFFF, 8'hFF));
		// extremes of value and priority, then fill up with one shared priority
		pending_requests.push_back(make_request(spq_pkg::FUNC_ENQUEUE, 16'hFFFF, 8'hFF));
		pending_requests.push_back(make_request(spq_pkg::FUNC_ENQUEUE, 0, 0));
		for (k = 0; k < CAPACITY - 2; k++)
			pending_requests.push_back(make_request(spq_pkg::FUNC_ENQUEUE, 16'h1000 + k, 5));
		// rejected when full, absent priority, a bulk removal, then drain to empty
		pending_requests.push_back(make_request(spq_pkg::FUNC_ENQUEUE, 16'hA5A5, 5));
		pending_requests.push_back(make_request(spq_pkg::FUNC_REMOVE, 0, 99));
		pending_requests.push_back(make_request(spq_pkg::FUNC_REMOVE, 0, 5));
		pending_requests.push_back(make_request(spq_pkg::FUNC_DEQUEUE, 0, 0));
		pending_requests.push_back(make_request(spq_pkg::FUNC_DEQUEUE, 0, 0));
		pending_requests.push_back(make_request(spq_pkg::FUNC_DEQUEUE, 0, 0));
		wait_quiet();

		for (k = 0; k < 4; k++) begin
			sender_idle_pct    = idle_table[k][0];
			receiver_stall_pct = idle_table[k][1];
			queue_random_bursts(RANDOM_ITEMS);
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		while (awaited_responses.size() != 0) begin
			void'(awaited_responses.pop_front());
			report("predicted response never arrived");
		end

		$display("Covered %0d requests: %0d inserts, %0d full rejects, %0d pops, %0d empty",
			requests_sent, n_inserted, n_rejected, n_popped, n_empty_hits);
		$display("  %0d removals (%0d emptied the list), %0d not found, %0d unused, %0d full",
			n_purged, n_whole_purge, n_notfound, n_nop, n_full_seen);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
